[src/ppdh_pkg.sv]
// Shared constants and types for the pulse period, duty and hue monitor.
`default_nettype none

package ppdh_pkg;

	localparam int COUNT_WIDTH_DEF    = 32;
	localparam int DUTY_FRAC_BITS_DEF = 16;
	localparam int OUT_W              = 32;
	localparam int DUTY_OUT_W         = 16;
	localparam int RED_W              = 5;
	localparam int GREEN_W            = 6;
	localparam int BLUE_W             = 5;
	localparam int COLOR_W            = RED_W + GREEN_W + BLUE_W;

	localparam logic [OUT_W-1:0] TPS_RESET = 32'd1000000;
	localparam logic [OUT_W-1:0] OUT_MAX   = 32'hFFFF_FFFF;

	// meter to control: closing edge seen this cycle, counter saturated
	typedef struct packed {
		logic close;
		logic sat;
	} ppdh_meas_t;

endpackage

`default_nettype wire

[src/ppdh_meter.sv]
// Edge tracker with saturating period and high-time counters.
`default_nettype none

module ppdh_meter #(
	parameter int COUNT_WIDTH = ppdh_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic                   level,
	output ppdh_pkg::ppdh_meas_t        meas,
	output logic [COUNT_WIDTH-1:0]      period_cnt,
	output logic [COUNT_WIDTH-1:0]      high_cnt
);

	typedef enum logic [1:0] {
		PH_WAIT_LOW,
		PH_WAIT_RISE,
		PH_HIGH,
		PH_LOW
	} phase_t;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	phase_t                 phase_q;
	logic [COUNT_WIDTH-1:0] period_q;
	logic [COUNT_WIDTH-1:0] high_q;
	logic                   sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_LOW;
			period_q <= '0;
			high_q   <= '0;
			sat_q    <= 1'b0;
		end else if (step) begin
			unique case (phase_q)
				PH_WAIT_LOW: begin
					if (!level)
						phase_q <= PH_WAIT_RISE;
				end
				PH_WAIT_RISE: begin
					if (level) begin
						sat_q    <= 1'b0;
						period_q <= COUNT_WIDTH'(1);
						high_q   <= COUNT_WIDTH'(1);
						phase_q  <= PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (period_q == CNT_MAX)
						sat_q <= 1'b1;
					else
						period_q <= period_q + COUNT_WIDTH'(1);
					if (level) begin
						if (high_q == CNT_MAX)
							sat_q <= 1'b1;
						else
							high_q <= high_q + COUNT_WIDTH'(1);
					end else begin
						phase_q <= PH_LOW;
					end
				end
				PH_LOW: begin
					if (level) begin
						// closing rise: counts stay put for the result
						phase_q <= PH_WAIT_LOW;
					end else if (period_q == CNT_MAX) begin
						sat_q <= 1'b1;
					end else begin
						period_q <= period_q + COUNT_WIDTH'(1);
					end
				end
			endcase
		end
	end

	assign meas.close = step && (phase_q == PH_LOW) && level;
	assign meas.sat   = sat_q;
	assign period_cnt = period_q;
	assign high_cnt   = high_q;

endmodule

`default_nettype wire

[src/ppdh_serial_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module ppdh_serial_div #(
	parameter int DEN_W = ppdh_pkg::COUNT_WIDTH_DEF,
	parameter int Q_W   = ppdh_pkg::OUT_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DEN_W-1:0] init_rem,
	input  wire logic [Q_W-1:0]   dividend,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [Q_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   quo_q;   // dividend bits out at the top, quotient bits in at the bottom

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, quo_q[Q_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(Q_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= init_rem;
			den_q <= den;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

[src/ppdh_hue.sv]
// Two-stage duty to RGB565 hue converter (full saturation and value).
`default_nettype none

module ppdh_hue #(
	parameter int DUTY_FRAC_BITS = ppdh_pkg::DUTY_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [DUTY_FRAC_BITS-1:0]   duty,
	output logic                             busy,
	output logic [ppdh_pkg::COLOR_W-1:0]     color
);

	localparam int F = DUTY_FRAC_BITS;

	logic [F+2:0] h6;
	logic         v_s1;
	logic [2:0]   sector_s1;
	logic [F:0]   up_s1;
	logic [F:0]   down_s1;

	logic [F:0]   lr, lg, lb;
	logic [F+5:0] pr, pb;
	logic [F+6:0] pg;
	logic [ppdh_pkg::COLOR_W-1:0] color_s2;

	assign h6 = {1'b0, duty, 2'b00} + {2'b00, duty, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sector_s1 <= h6[F+2:F];
			up_s1     <= {1'b0, h6[F-1:0]};
			down_s1   <= {1'b1, {F{1'b0}}} - {1'b0, h6[F-1:0]};
		end
	end

	always_comb begin
		lr = '0;
		lg = '0;
		lb = '0;
		unique case (sector_s1)
			3'd0: begin lr = {1'b1, {F{1'b0}}}; lg = up_s1;   lb = '0;                 end
			3'd1: begin lr = down_s1;           lg = {1'b1, {F{1'b0}}}; lb = '0;       end
			3'd2: begin lr = '0;                lg = {1'b1, {F{1'b0}}}; lb = up_s1;    end
			3'd3: begin lr = '0;                lg = down_s1; lb = {1'b1, {F{1'b0}}};  end
			3'd4: begin lr = up_s1;             lg = '0;      lb = {1'b1, {F{1'b0}}};  end
			default: begin lr = {1'b1, {F{1'b0}}}; lg = '0;   lb = down_s1;            end
		endcase
		// level * 31 and level * 63 as shift and subtract
		pr = {lr, 5'b0} - {5'b0, lr};
		pb = {lb, 5'b0} - {5'b0, lb};
		pg = {lg, 6'b0} - {6'b0, lg};
	end

	always_ff @(posedge clk) begin
		if (v_s1)
			color_s2 <= {pr[F+4:F], pg[F+5:F], pb[F+4:F]};
	end

	assign busy  = v_s1;
	assign color = color_s2;

endmodule

`default_nettype wire

[src/pulse_period_duty_hue_monitor.sv]
// Top level: pin sampler, serial dividers, hue stage and result register.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    level
//  out      output     out_valid / out_stall  period_ticks high_ticks duty_fraction
//                                             frequency_hz hue_color overflowed
//  cfg      input      cfg_valid / cfg_ready  ticks_per_second
//
// While idle, samples that close no period are taken back to back.
// A closing rising edge runs the bit-serial frequency and duty dividers,
// followed by the two-stage hue unit.
// While that runs in_stall is high; a result waiting in the output register
// does not stall input until the next closing edge needs the register.
// Reset clears phase, counters and handshake state; tick rate resets to 1000000.
`default_nettype none

module pulse_period_duty_hue_monitor #(
	parameter int COUNT_WIDTH    = ppdh_pkg::COUNT_WIDTH_DEF,
	parameter int DUTY_FRAC_BITS = ppdh_pkg::DUTY_FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               level,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ppdh_pkg::OUT_W-1:0]              period_ticks,
	output logic [ppdh_pkg::OUT_W-1:0]              high_ticks,
	output logic [ppdh_pkg::DUTY_OUT_W-1:0]         duty_fraction,
	output logic [ppdh_pkg::OUT_W-1:0]              frequency_hz,
	output logic [ppdh_pkg::COLOR_W-1:0]            hue_color,
	output logic                                    overflowed,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ppdh_pkg::OUT_W-1:0]         ticks_per_second
);

	localparam int F     = DUTY_FRAC_BITS;
	localparam int OW    = ppdh_pkg::OUT_W;
	localparam int EXT_W = (COUNT_WIDTH > OW) ? COUNT_WIDTH : OW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HUE
	} state_t;

	state_t                 state_q;
	logic [OW-1:0]          tps_q;
	logic [F-1:0]           duty_q;

	logic                   in_accept;
	ppdh_pkg::ppdh_meas_t   meas;
	logic [COUNT_WIDTH-1:0] period_cnt;
	logic [COUNT_WIDTH-1:0] high_cnt;

	logic                   duty_busy, freq_busy, hue_busy;
	logic [F-1:0]           duty_quo;
	logic [OW-1:0]          freq_quo;
	logic [ppdh_pkg::COLOR_W-1:0] color;

	logic                   div_done, out_load;
	logic [F-1:0]           duty_sel;
	logic [EXT_W-1:0]       period_ext, high_ext;
	logic                   period_big, high_big;
	logic [F+15:0]          duty_wide;

	logic                   out_valid_q, ovf_q;
	logic [OW-1:0]          period_q, high_q, freq_q;
	logic [ppdh_pkg::DUTY_OUT_W-1:0] frac_q;
	logic [ppdh_pkg::COLOR_W-1:0]    color_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tps_q <= ppdh_pkg::TPS_RESET;
		else if (cfg_valid && cfg_ready)
			tps_q <= ticks_per_second;
	end

	ppdh_meter #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_meter (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_accept),
		.level      (level),
		.meas       (meas),
		.period_cnt (period_cnt),
		.high_cnt   (high_cnt)
	);

	ppdh_serial_div #(
		.DEN_W(COUNT_WIDTH),
		.Q_W  (F)
	) u_duty_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (meas.close),
		.init_rem (high_cnt),
		.dividend ({F{1'b0}}),
		.den      (period_cnt),
		.busy     (duty_busy),
		.quotient (duty_quo)
	);

	ppdh_serial_div #(
		.DEN_W(COUNT_WIDTH),
		.Q_W  (OW)
	) u_freq_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (meas.close),
		.init_rem ({COUNT_WIDTH{1'b0}}),
		.dividend (tps_q),
		.den      (period_cnt),
		.busy     (freq_busy),
		.quotient (freq_quo)
	);

	assign div_done = (state_q == ST_DIV) && !duty_busy && !freq_busy;

	// zero period gives zero duty; high not below period gives all ones
	always_comb begin
		if (period_cnt == '0)
			duty_sel = '0;
		else if (high_cnt >= period_cnt)
			duty_sel = '1;
		else
			duty_sel = duty_quo;
	end

	ppdh_hue #(
		.DUTY_FRAC_BITS(F)
	) u_hue (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_done),
		.duty   (duty_sel),
		.busy   (hue_busy),
		.color  (color)
	);

	always_comb begin
		period_ext = EXT_W'(period_cnt);
		high_ext   = EXT_W'(high_cnt);
		period_big = period_ext > EXT_W'(ppdh_pkg::OUT_MAX);
		high_big   = high_ext > EXT_W'(ppdh_pkg::OUT_MAX);
		duty_wide  = {duty_q, 16'b0} >> F;
	end

	assign out_load = (state_q == ST_HUE) && !hue_busy && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (meas.close) state_q <= ST_DIV;
				ST_DIV:  if (div_done)   state_q <= ST_HUE;
				ST_HUE:  if (out_load)   state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done)
			duty_q <= duty_sel;
		if (out_load) begin
			period_q <= period_big ? ppdh_pkg::OUT_MAX : period_ext[OW-1:0];
			high_q   <= high_big ? ppdh_pkg::OUT_MAX : high_ext[OW-1:0];
			frac_q   <= duty_wide[15:0];
			freq_q   <= (period_cnt == '0) ? '0 : freq_quo;
			color_q  <= color;
			ovf_q    <= meas.sat || period_big || high_big;
		end
	end

	assign out_valid     = out_valid_q;
	assign period_ticks  = period_q;
	assign high_ticks    = high_q;
	assign duty_fraction = frac_q;
	assign frequency_hz  = freq_q;
	assign hue_color     = color_q;
	assign overflowed    = ovf_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(duty_busy || freq_busy || hue_busy) |-> in_stall)
		else $error("divider or hue unit busy while input open");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!duty_busy && !freq_busy && !hue_busy))
		else $error("unit busy in idle state");

	a_close_starts: assert property (@(posedge clk) disable iff (!arst_n)
		meas.close |=> (state_q == ST_DIV && duty_busy && freq_busy))
		else $error("closing edge did not start the dividers");

	a_load_from_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == ST_IDLE))
		else $error("result load did not present a word");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Testbench for the pulse period, duty and hue monitor: random pin waveforms, scoreboard check.
module tb_top;

	localparam int SETTLE_CYCLES = 60;
	localparam int STUCK_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 700;

	typedef enum logic [1:0] {WAIT_LOW, WAIT_RISE, IN_HIGH, IN_LOW} pin_phase_t;

	typedef struct packed {
		logic [ppdh_pkg::OUT_W-1:0]      period;
		logic [ppdh_pkg::OUT_W-1:0]      high;
		logic [ppdh_pkg::DUTY_OUT_W-1:0] duty;
		logic [ppdh_pkg::OUT_W-1:0]      freq;
		logic [ppdh_pkg::COLOR_W-1:0]    color;
		logic                            ovf;
	} reading_t;

	class pwm_scoreboard;
		logic [ppdh_pkg::OUT_W-1:0] rate;
		pin_phase_t       phase;
		logic [31:0]      per_cnt;
		logic [31:0]      high_cnt;
		bit               saturated;
		reading_t         owed_readings[$];
		int               readings_due;
		int               errors;

		function new();
			rate         = ppdh_pkg::TPS_RESET;
			phase        = WAIT_LOW;
			per_cnt      = '0;
			high_cnt     = '0;
			saturated    = 1'b0;
			readings_due = 0;
			errors       = 0;
		endfunction

		function logic [31:0] bumped(logic [31:0] c);
			if (c == '1) begin
				saturated = 1'b1;
				return c;
			end
			return c + 32'd1;
		endfunction

		// full-saturation, full-value hue wheel, scaled to 5/6/5 bits
		function logic [ppdh_pkg::COLOR_W-1:0] hue565(logic [ppdh_pkg::DUTY_OUT_W-1:0] d);
			int unsigned h6, up, dn, rl, gl, bl, r5, g6, b5;
			h6 = 6 * 32'(d);
			up = h6 & 32'hFFFF;
			dn = 32'h10000 - up;
			case (h6 >> 16)
			0: begin
				rl = 32'h10000; gl = up; bl = 0;
			end
			1: begin
				rl = dn; gl = 32'h10000; bl = 0;
			end
			2: begin
				rl = 0; gl = 32'h10000; bl = up;
			end
			3: begin
				rl = 0; gl = dn; bl = 32'h10000;
			end
			4: begin
				rl = up; gl = 0; bl = 32'h10000;
			end
			default: begin
				rl = 32'h10000; gl = 0; bl = dn;
			end
			endcase
			r5 = (rl * 31) >> 16;
			g6 = (gl * 63) >> 16;
			b5 = (bl * 31) >> 16;
			return {r5[ppdh_pkg::RED_W-1:0], g6[ppdh_pkg::GREEN_W-1:0],
				b5[ppdh_pkg::BLUE_W-1:0]};
		endfunction

		function void take_level(bit lv);
			reading_t   r;
			logic [63:0] num;
			case (phase)
			WAIT_LOW: begin
				if (!lv)
					phase = WAIT_RISE;
			end
			WAIT_RISE: begin
				if (lv) begin
					saturated = 1'b0;
					per_cnt   = 32'd1;
					high_cnt  = 32'd1;
					phase     = IN_HIGH;
				end
			end
			IN_HIGH: begin
				per_cnt = bumped(per_cnt);
				if (lv)
					high_cnt = bumped(high_cnt);
				else
					phase = IN_LOW;
			end
			default: begin
				if (!lv) begin
					per_cnt = bumped(per_cnt);
				end else begin
					// closing rising edge
					phase = WAIT_LOW;
					if (per_cnt == 0) begin
						r.duty = '0;
					end else if (high_cnt >= per_cnt) begin
						r.duty = '1;
					end else begin
						num    = 64'({high_cnt, 16'h0});
						r.duty = 16'(num / 64'(per_cnt));
					end
					r.period = per_cnt;
					r.high   = high_cnt;
					r.freq   = (per_cnt == 0) ? '0 : rate / per_cnt;
					r.color  = hue565(r.duty);
					r.ovf    = saturated;
					owed_readings.push_back(r);
					readings_due++;
				end
			end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			if (owed_readings.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, got);
				errors++;
				return;
			end
			want = owed_readings.pop_front();
			compare_field("period_ticks", want.period, got.period);
			compare_field("high_ticks", want.high, got.high);
			compare_field("duty_fraction", 32'(want.duty), 32'(got.duty));
			compare_field("frequency_hz", want.freq, got.freq);
			compare_field("hue_color", 32'(want.color), 32'(got.color));
			compare_field("overflowed", 32'(want.ovf), 32'(got.ovf));
		endfunction
	endclass

	logic                            clk              = 1'b0;
	logic                            arst_n           = 1'b0;
	logic                            in_valid         = 1'b0;
	logic                            in_stall;
	logic                            level            = 1'b0;
	logic                            out_valid;
	logic                            out_stall        = 1'b1;
	logic [ppdh_pkg::OUT_W-1:0]      period_ticks;
	logic [ppdh_pkg::OUT_W-1:0]      high_ticks;
	logic [ppdh_pkg::DUTY_OUT_W-1:0] duty_fraction;
	logic [ppdh_pkg::OUT_W-1:0]      frequency_hz;
	logic [ppdh_pkg::COLOR_W-1:0]    hue_color;
	logic                            overflowed;
	logic                            cfg_valid        = 1'b0;
	logic                            cfg_ready;
	logic [ppdh_pkg::OUT_W-1:0]      ticks_per_second = '0;

	pwm_scoreboard board;
	int tx_idle_pct = 38;
	int rx_idle_pct = 80;
	int hold_left   = 0;
	int sent        = 0;
	int stuck       = 0;

	pulse_period_duty_hue_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.level(level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.period_ticks(period_ticks),
		.high_ticks(high_ticks),
		.duty_fraction(duty_fraction),
		.frequency_hz(frequency_hz),
		.hue_color(hue_color),
		.overflowed(overflowed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.ticks_per_second(ticks_per_second)
	);

	always #4 clk = ~clk;

	// result side: check accepted words, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_reading({period_ticks, high_ticks, duty_fraction, frequency_hz,
				hue_color, overflowed});
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	task automatic send_level(input bit lv);
		level    <= lv;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.take_level(lv);
		sent++;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	// stop offering words, let every owed reading come out, then idle a while
	task automatic settle();
		if (in_valid)
			in_valid <= 1'b0;
		while (board.owed_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [ppdh_pkg::OUT_W-1:0] v);
		settle();
		cfg_valid        <= 1'b1;
		ticks_per_second <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		board.rate = v;
	endtask

	function automatic int pick_len();
		return ($urandom_range(19) == 0) ? $urandom_range(200, 1) : $urandom_range(12, 1);
	endfunction

	// mostly steady pulse trains; some random noise and stuck levels
	task automatic drive_wave(input int words, input int min_readings);
		int n0, r0, kind, hi_len, lo_len;
		n0 = sent;
		r0 = board.readings_due;
		while (sent - n0 < words || board.readings_due - r0 < min_readings) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				hi_len = pick_len();
				lo_len = pick_len();
				repeat ($urandom_range(6, 2)) begin
					repeat (hi_len) send_level(1'b1);
					repeat (lo_len) send_level(1'b0);
				end
			end else if (kind < 94) begin
				repeat ($urandom_range(20, 1)) send_level(1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(40, 1)) send_level(kind[0]);
			end
		end
	endtask

	bit opener[25] = '{0, 1, 0, 1,
		1, 0, 1, 1, 1, 1, 1, 1, 1, 0, 1,
		0, 1, 0, 0, 0, 0, 0, 0, 0, 1};

	initial begin
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest period, long high, long low, all at the reset tick rate
		foreach (opener[i])
			send_level(opener[i]);

		write_rate(ppdh_pkg::OUT_MAX);
		drive_wave(360, 12);

		tx_idle_pct = 80;
		rx_idle_pct = 38;
		write_rate(32'd1);
		hold_left = HOLD_CYCLES;
		drive_wave(360, 12);

		// zero tick rate gives zero frequency
		write_rate('0);
		drive_wave(230, 12);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_rate($urandom);
		drive_wave(540, 12);

		settle();
		if (board.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
